### design/moving_average_filter_macros.svh
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/maf_pkg.sv
`default_nettype none

package maf_pkg;

  localparam int RING_DEPTH_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int WIN_W      = 7;
  localparam int CFG_DATA_W = 8;

  localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

endpackage

`default_nettype wire

### design/moving_average_filter.sv
// Moving average over the last window_length samples.
//
// Channels: in_* takes one signed sample per word, out_* gives one average
// per sample, cfg_* writes window_length (always ready; write it only while
// no sample is in flight). Window 0 acts as 1, a window above RING_DEPTH
// acts as RING_DEPTH.
//
// After reset the block clears its sample ring, one entry per cycle, and
// holds in_tready low until the whole ring is clear. Sum, index and window reset too.
//
// Each sample holds the block through these steps: subtract the oldest
// sample, add the new one, take the magnitude, then a restoring division by
// the window at one quotient bit per cycle (SUM_W steps), then sign and
// saturation. in_tready is high only between samples, so the block takes no
// new sample until the previous one is through.
//
// The result sits in an output register; a stalled receiver does not stop
// the next sample from being taken. Only if the receiver still holds the
// previous average when the next one is ready does the block wait.
`default_nettype none

`include "moving_average_filter_macros.svh"

module moving_average_filter #(
  parameter int RING_DEPTH   = maf_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,   // [SW-1:0] sample
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0]       out_tdata,  // [SW-1:0] average
  input  wire logic                                    cfg_tvalid,
  output logic                                         cfg_tready,
  input  wire logic [maf_pkg::CFG_DATA_W-1:0]          cfg_tdata   // [6:0] window_length
);

  import maf_pkg::*;

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_WIDTH + IDX_W + 1;
  localparam int AW     = SUM_W + 1;
  localparam int CNT_W  = $clog2(SUM_W);

  localparam logic [SUM_W-1:0] MAX_POS = SUM_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] MAX_NEG = SUM_W'(64'd1 << (SAMPLE_WIDTH - 1));

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SUB   = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_ABS   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIX   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         clr_r, clr_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [SUM_W-1:0]         quo_r, quo_nxt;
  logic [WIN_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [SAMPLE_WIDTH-1:0]  samp_r, samp_nxt;
  logic [WIN_W-1:0]         window_r, window_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0]  out_data_r, out_data_nxt;
  logic [SAMPLE_WIDTH-1:0]  avg;

  logic [SAMPLE_WIDTH-1:0]  ring [RING_DEPTH];
  logic [SAMPLE_WIDTH-1:0]  rd_data_r;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_addr;
  logic [SAMPLE_WIDTH-1:0]  mem_wdata;

  logic [WIN_W-1:0]         eff_w;
  logic [WIN_W:0]           trial;
  logic                     ge;
  logic [AW-1:0]            add_a, add_b, add_res;
  logic                     add_sub;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);

  always_comb begin
    if (window_r == '0) begin
      eff_w = WIN_W'(1);
    end else if (int'(window_r) > RING_DEPTH) begin
      eff_w = WIN_W'(RING_DEPTH);
    end else begin
      eff_w = window_r;
    end
  end

  // shared adder/subtractor
  assign trial = {rem_r, quo_r[SUM_W-1]};

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_SUB: begin
        add_a   = {sum_r[SUM_W-1], sum_r};
        add_b   = {{(AW-SAMPLE_WIDTH){rd_data_r[SAMPLE_WIDTH-1]}}, rd_data_r};
        add_sub = 1'b1;
      end
      S_ADD: begin
        add_a   = {sum_r[SUM_W-1], sum_r};
        add_b   = {{(AW-SAMPLE_WIDTH){samp_r[SAMPLE_WIDTH-1]}}, samp_r};
      end
      S_ABS: begin
        add_b   = {sum_r[SUM_W-1], sum_r};
        add_sub = sum_r[SUM_W-1];
      end
      S_DIV: begin
        add_a   = AW'(trial);
        add_b   = AW'(eff_w);
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign add_res = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
  assign ge      = !add_res[AW-1];

  // sign and saturation of the quotient
  always_comb begin
    if (!sum_r[SUM_W-1]) begin
      avg = (quo_r > MAX_POS) ? MAX_POS[SAMPLE_WIDTH-1:0] : quo_r[SAMPLE_WIDTH-1:0];
    end else if (quo_r > MAX_NEG) begin
      avg = MAX_NEG[SAMPLE_WIDTH-1:0];
    end else begin
      avg = -quo_r[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    samp_nxt      = samp_r;
    window_nxt    = window_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = idx_r;
    mem_wdata     = samp_r;

    if (cfg_tvalid && cfg_tready) begin
      window_nxt = cfg_tdata[WIN_W-1:0];
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IDX_W'(RING_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          samp_nxt  = in_tdata[SAMPLE_WIDTH-1:0];
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        mem_we    = 1'b1;
        sum_nxt   = add_res[SUM_W-1:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        sum_nxt   = add_res[SUM_W-1:0];
        idx_nxt   = (int'(idx_r) + 1 > int'(eff_w) - 1) ? '0 : idx_r + 1'b1;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        quo_nxt   = add_res[SUM_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(SUM_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? add_res[WIN_W-1:0] : trial[WIN_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = avg;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_addr] <= mem_wdata;
    end
    rd_data_r <= ring[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      window_r    <= WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      window_r    <= window_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    samp_r     <= samp_nxt;
    out_data_r <= out_data_nxt;
  end

  `MAF_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready && state_r == S_SUB, "not busy")
  `MAF_ASSERT_NOW(a_idx_in_ring, 1'b1, int'(idx_r) < RING_DEPTH, "write index beyond ring")
  `MAF_ASSERT_NOW(a_rem_below_div, state_r == S_DIV, rem_r < eff_w, "remainder too big")
  `MAF_ASSERT_NOW(a_out_fix, $rose(out_valid_r), $past(state_r) == S_FIX, "valid outside S_FIX")

endmodule

`default_nettype wire

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW    = maf_pkg::SAMPLE_WIDTH_DEF;
  localparam int DEPTH = maf_pkg::RING_DEPTH_DEF;
  localparam int DW    = ((SW + 7) / 8) * 8;
  localparam int NPHASE = 8;
  localparam int PHASE_ITEMS = 92;

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  class avg_scoreboard;
    logic signed [SW-1:0] ring [DEPTH];
    int                   sum;
    int                   wr_idx;
    logic [maf_pkg::WIN_W-1:0] window;
    logic [SW-1:0]        expected_avgs [$];
    int                   n_errors;
    int                   n_checked;

    function new();
      foreach (ring[k]) ring[k] = '0;
      sum       = 0;
      wr_idx    = 0;
      window    = maf_pkg::WIN_RESET;
      n_errors  = 0;
      n_checked = 0;
    endfunction

    function void set_window(logic [maf_pkg::WIN_W-1:0] w);
      window = w;
    endfunction

    function int pending();
      return expected_avgs.size();
    endfunction

    // advance the ring and sum, queue the average this sample produces
    function void note_sample(logic signed [SW-1:0] s);
      int w;
      int idx;
      int q;
      w = (window == 0) ? 1 : ((window > DEPTH) ? DEPTH : int'(window));
      idx = wr_idx % DEPTH;
      sum = sum - int'(ring[idx]) + int'(s);
      ring[idx] = s;
      idx++;
      if (idx > w - 1) idx = 0;
      wr_idx = idx;
      q = sum / w;
      if (q > int'($signed(S_MAX))) q = int'($signed(S_MAX));
      if (q < int'($signed(S_MIN))) q = int'($signed(S_MIN));
      expected_avgs.push_back(q[SW-1:0]);
    endfunction

    function void check_average(logic [SW-1:0] actual);
      logic [SW-1:0] exp_avg;
      if (expected_avgs.size() == 0) begin
        $error("average: unexpected word, actual %0d", $signed(actual));
        n_errors++;
        return;
      end
      exp_avg = expected_avgs.pop_front();
      n_checked++;
      if (actual !== exp_avg) begin
        $error("average mismatch: expected %0d, actual %0d", $signed(exp_avg), $signed(actual));
        n_errors++;
      end
    endfunction
  endclass

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [DW-1:0]                in_tdata   = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [DW-1:0]                out_tdata;
  logic                         cfg_tvalid = 1'b0;
  logic                         cfg_tready;
  logic [maf_pkg::CFG_DATA_W-1:0] cfg_tdata = '0;

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_sent    = 0;
  int n_windows = 0;

  avg_scoreboard sb = new();

  moving_average_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_average(out_tdata[SW-1:0]);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_sample(input logic [SW-1:0] s);
    in_tvalid <= 1'b1;
    in_tdata  <= DW'(s);
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
    n_sent++;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= DW'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_window(input logic [maf_pkg::WIN_W-1:0] w);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {$urandom_range(1) == 1, w};
    do @(posedge clk); while (!cfg_tready);
    sb.set_window(w);
    n_windows++;
    cfg_tvalid <= 1'b0;
  endtask

  function automatic logic [SW-1:0] pick_sample(input int bias);
    int r;
    logic [SW-1:0] v;
    r = $urandom_range(99);
    if (bias != 0 && r < 70) return (bias > 0) ? S_MAX : S_MIN;
    if (r < 10) return S_MAX;
    if (r < 20) return S_MIN;
    if (r < 35) begin
      v = SW'($urandom_range(16));
      return v - SW'(8);
    end
    return SW'($urandom);
  endfunction

  initial begin
    int phase_bias [NPHASE];
    logic [maf_pkg::WIN_W-1:0] w;
    int mode;

    phase_bias = '{1, 0, -1, 0, 0, 0, 0, 1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes at the reset window of 64
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
    send_sample('1);
    send_sample(SW'(1));
    send_sample(16'h5555);
    send_sample(16'haaaa);
    drain();
    // shrink below the write index, then to 1 so stale entries overflow the average
    write_window(7'd3);
    repeat (3) send_sample(S_MAX);
    drain();
    write_window(7'd1);
    send_sample(S_MAX);
    drain();
    write_window(7'd3);
    repeat (3) send_sample(S_MIN);
    drain();
    write_window(7'd1);
    send_sample(S_MIN);
    drain();
    // zero acts as 1, above depth acts as depth
    write_window(7'd0);
    send_sample(SW'(5));
    drain();
    write_window(7'd127);
    send_sample(S_MAX);
    send_sample(SW'(3));
    drain();

    for (int ph = 0; ph < NPHASE; ph++) begin
      case (ph)
        0, 6:    w = 7'd64;
        1:       w = 7'd1;
        2:       w = 7'd127;
        3:       w = 7'd5;
        4:       w = 7'd0;
        5:       w = 7'($urandom_range(2, 63));
        default: w = 7'($urandom_range(1, 64));
      endcase
      write_window(w);
      mode = ph % 4;
      idle_pct  = (mode == 1) ? 74 : ((mode == 3) ? 30 : 0);
      stall_pct = (mode == 2) ? 74 : ((mode == 3) ? 30 : 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2) drain();
        send_sample(pick_sample(phase_bias[ph]));
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (60) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("average: %0d expected words never arrived", sb.pending());
      sb.n_errors++;
    end

    $display("Sent %0d samples over %0d window settings, checked %0d averages,",
             n_sent, n_windows, sb.n_checked);
    $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
    if (sb.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
